// ===== design/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MA_XO_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ma_xo: property failed");

// Same-cycle implication checked outside reset.
`define MA_XO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ma_xo: implication failed");

`endif

// ===== design/ma_xo_pkg.sv =====
// ---------------------------------------------------------------------------
// ma_xo_pkg
// Shared types and constants of the moving average crossover block.
// ---------------------------------------------------------------------------
package ma_xo_pkg;

    // Configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd1;

    // Window reset values
    localparam int SHORT_RESET = 20;
    localparam int LONG_RESET  = 50;

    // Averages are 24.8 fixed point
    localparam int FRAC_BITS = 8;
    localparam int AVG_W     = 32;

    // Relation of short average to long average
    typedef logic [1:0] rel_t;
    localparam rel_t REL_EQUAL = 2'd0;
    localparam rel_t REL_ABOVE = 2'd1;
    localparam rel_t REL_BELOW = 2'd2;

    // Crossover signal codes
    typedef logic [1:0] sig_t;
    localparam sig_t SIG_NONE = 2'd0;
    localparam sig_t SIG_BUY  = 2'd1;
    localparam sig_t SIG_SELL = 2'd2;

endpackage

// ===== design/moving_average_crossover_top.sv =====
// From input transfer to result, an item passes ST_RD_S, ST_RD_L, ST_UPD, ST_RUN and ST_DONE;
//   bit-serial dividers set the ST_RUN length. A new item is taken once the result is loaded.
// After a window register write, the next item first re-sums the ring, reading and accumulating
//   each of the newest min(samples seen, larger window) samples in ST_SW_RD and ST_SW_ACC.
// Reset (rst_n low, asynchronous) empties the windows and restores windows 20 and 50;
//   the sample ring is not cleared, slots are only read once written.
// ---------------------------------------------------------------------------
// moving_average_crossover_top
// Simple moving average crossover detector with running window sums.
// ---------------------------------------------------------------------------
module moving_average_crossover_top
    import ma_xo_pkg::*;
#(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // price samples
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PRICE_BITS-1:0]  close_price,
    // results
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [AVG_W-1:0]       short_average,
    output logic [AVG_W-1:0]       long_average,
    output logic                   short_ready,
    output logic                   long_ready,
    output logic [1:0]             cross_signal
);

    // Widths: AW addresses the ring, WIN_W holds 1..MAX_WINDOW,
    // TOT_W holds a full window sum.
    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int TOT_W  = PRICE_BITS + $clog2(MAX_WINDOW);
    localparam int NUM_W  = TOT_W + FRAC_BITS;
    localparam int PROD_W = TOT_W + WIN_W;

    localparam logic [WIN_W-1:0] SHORT_INIT =
        WIN_W'((SHORT_RESET > MAX_WINDOW) ? MAX_WINDOW : SHORT_RESET);
    localparam logic [WIN_W-1:0] LONG_INIT  =
        WIN_W'((LONG_RESET > MAX_WINDOW) ? MAX_WINDOW : LONG_RESET);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for a sample
    localparam logic [2:0] ST_SW_RD  = 3'd1;  // re-sum: issue ring read
    localparam logic [2:0] ST_SW_ACC = 3'd2;  // re-sum: accumulate read data
    localparam logic [2:0] ST_RD_S   = 3'd3;  // read sample leaving short window
    localparam logic [2:0] ST_RD_L   = 3'd4;  // read sample leaving long window
    localparam logic [2:0] ST_UPD    = 3'd5;  // write sample, update sums, start units
    localparam logic [2:0] ST_RUN    = 3'd6;  // serial divide and multiply
    localparam logic [2:0] ST_DONE   = 3'd7;  // compare, load output register

    // Window register handling: zero means one, anything past the ring
    // depth means the whole ring.
    function automatic logic [WIN_W-1:0] clamp_win(input logic [CFG_W-1:0] v);
        logic [WIN_W-1:0] r;
        if (v == '0)
            r = WIN_W'(1);
        else if (32'(v) > 32'(MAX_WINDOW))
            r = WIN_W'(MAX_WINDOW);
        else
            r = WIN_W'(v);
        return r;
    endfunction

    // Slot that lies off places behind base, 1 <= off <= MAX_WINDOW.
    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0]    base,
                                                input logic [WIN_W-1:0] off);
        logic [AW:0] diff;
        diff = {1'b0, base} + (AW+1)'(MAX_WINDOW) - (AW+1)'(off);
        if (diff >= (AW+1)'(MAX_WINDOW))
            diff = diff - (AW+1)'(MAX_WINDOW);
        return diff[AW-1:0];
    endfunction

    logic [2:0]            state_reg;
    logic [2:0]            state_next;

    logic [WIN_W-1:0]      win_s_reg;
    logic [WIN_W-1:0]      win_l_reg;
    logic                  dirty_reg;      // window changed, sums need a re-sum

    logic [AW-1:0]         wp_reg;
    logic [WIN_W-1:0]      seen_reg;
    logic [TOT_W-1:0]      s_tot_reg;      // sum of newest min(seen, window) samples
    logic [TOT_W-1:0]      l_tot_reg;
    rel_t                  last_rel_reg;
    logic                  have_prev_reg;
    logic [WIN_W-1:0]      k_reg;          // re-sum index
    logic                  s_rdy_reg;
    logic                  l_rdy_reg;

    logic [PRICE_BITS-1:0] price_reg;
    logic [PRICE_BITS-1:0] s_out_reg;      // sample leaving the short window

    // Sample ring
    logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [AW-1:0]         rd_addr;
    logic [PRICE_BITS-1:0] rd_data_reg;
    logic                  mem_we;

    // Output register
    logic                  out_valid_reg;
    logic [AVG_W-1:0]      s_avg_reg;
    logic [AVG_W-1:0]      l_avg_reg;
    logic                  s_rdy_out_reg;
    logic                  l_rdy_out_reg;
    sig_t                  sig_reg;

    // Update datapath
    logic                  sub_s;
    logic                  sub_l;
    logic [WIN_W-1:0]      seen_inc;
    logic                  s_rdy;
    logic                  l_rdy;
    logic [TOT_W-1:0]      s_new;
    logic [TOT_W-1:0]      l_new;
    logic [TOT_W-1:0]      s_eff;
    logic [TOT_W-1:0]      l_eff;
    logic [AW-1:0]         wp_inc;

    // Re-sum limits
    logic [WIN_W-1:0]      lim_s;
    logic [WIN_W-1:0]      lim_l;
    logic [WIN_W-1:0]      sweep_len;

    // Serial units
    logic                  unit_start;
    logic                  div_s_busy;
    logic                  div_l_busy;
    logic                  mul_s_busy;
    logic                  mul_l_busy;
    logic [NUM_W-1:0]      s_quot;
    logic [NUM_W-1:0]      l_quot;
    logic [PROD_W-1:0]     lhs;
    logic [PROD_W-1:0]     rhs;
    logic                  units_busy;

    // Decision
    rel_t                  rel;
    sig_t                  sig;
    logic                  out_load;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    assign lim_s     = (seen_reg < win_s_reg) ? seen_reg : win_s_reg;
    assign lim_l     = (seen_reg < win_l_reg) ? seen_reg : win_l_reg;
    assign sweep_len = (lim_s > lim_l) ? lim_s : lim_l;

    // A sample leaves a window only once that window is already full.
    assign sub_s    = seen_reg >= win_s_reg;
    assign sub_l    = seen_reg >= win_l_reg;
    assign seen_inc = (seen_reg == WIN_W'(MAX_WINDOW)) ? seen_reg : seen_reg + 1'b1;
    assign s_rdy    = seen_inc >= win_s_reg;
    assign l_rdy    = seen_inc >= win_l_reg;

    // rd_data_reg holds the long window's leaving sample in ST_UPD
    assign s_new = s_tot_reg + TOT_W'(price_reg) - (sub_s ? TOT_W'(s_out_reg) : '0);
    assign l_new = l_tot_reg + TOT_W'(price_reg) - (sub_l ? TOT_W'(rd_data_reg) : '0);
    assign s_eff = s_rdy ? s_new : '0;
    assign l_eff = l_rdy ? l_new : '0;

    assign wp_inc = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;

    always_comb
    begin
        case (state_reg)
            ST_SW_RD: rd_addr = ring_back(wp_reg, k_reg + 1'b1);
            ST_RD_S:  rd_addr = ring_back(wp_reg, win_s_reg);
            default:  rd_addr = ring_back(wp_reg, win_l_reg);
        endcase
    end

    assign mem_we     = (state_reg == ST_UPD);
    assign unit_start = (state_reg == ST_UPD);
    assign units_busy = div_s_busy | div_l_busy | mul_s_busy | mul_l_busy;

    // Exact comparison: short_total * long_window against long_total * short_window
    always_comb
    begin
        if (lhs > rhs)
            rel = REL_ABOVE;
        else if (lhs < rhs)
            rel = REL_BELOW;
        else
            rel = REL_EQUAL;

        sig = SIG_NONE;
        if (have_prev_reg)
        begin
            if (rel == REL_ABOVE && last_rel_reg != REL_ABOVE)
                sig = SIG_BUY;
            else if (rel == REL_BELOW && last_rel_reg != REL_BELOW)
                sig = SIG_SELL;
        end
    end

    // Result goes out once the output register is free
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = dirty_reg ? ST_SW_RD : ST_RD_S;
            end
            ST_SW_RD:
            begin
                if (k_reg < sweep_len)
                    state_next = ST_SW_ACC;
                else
                    state_next = ST_RD_S;
            end
            ST_SW_ACC: state_next = ST_SW_RD;
            ST_RD_S:   state_next = ST_RD_L;
            ST_RD_L:   state_next = ST_UPD;
            ST_UPD:    state_next = ST_RUN;
            ST_RUN:
            begin
                if (!units_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_s_reg     <= SHORT_INIT;
            win_l_reg     <= LONG_INIT;
            dirty_reg     <= 1'b0;
            wp_reg        <= '0;
            seen_reg      <= '0;
            s_tot_reg     <= '0;
            l_tot_reg     <= '0;
            last_rel_reg  <= REL_EQUAL;
            have_prev_reg <= 1'b0;
            k_reg         <= '0;
            s_rdy_reg     <= 1'b0;
            l_rdy_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Window changes are to be written by the user only between items; the block does not enforce it
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_SHORT:
                    begin
                        win_s_reg <= clamp_win(cfg_data);
                        dirty_reg <= 1'b1;
                    end
                    REG_LONG:
                    begin
                        win_l_reg <= clamp_win(cfg_data);
                        dirty_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && dirty_reg)
                    begin
                        s_tot_reg <= '0;
                        l_tot_reg <= '0;
                        k_reg     <= '0;
                    end
                end
                ST_SW_RD:
                begin
                    if (k_reg >= sweep_len)
                        dirty_reg <= 1'b0;
                end
                ST_SW_ACC:
                begin
                    if (k_reg < lim_s)
                        s_tot_reg <= s_tot_reg + TOT_W'(rd_data_reg);
                    if (k_reg < lim_l)
                        l_tot_reg <= l_tot_reg + TOT_W'(rd_data_reg);
                    k_reg <= k_reg + 1'b1;
                end
                ST_UPD:
                begin
                    s_tot_reg <= s_new;
                    l_tot_reg <= l_new;
                    seen_reg  <= seen_inc;
                    wp_reg    <= wp_inc;
                    s_rdy_reg <= s_rdy;
                    l_rdy_reg <= l_rdy;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        last_rel_reg  <= rel;
                        have_prev_reg <= 1'b1;
                    end
                end
                default: ;
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            price_reg <= close_price;
        if (state_reg == ST_RD_L)
            s_out_reg <= rd_data_reg;
        if (out_load)
        begin
            s_avg_reg     <= AVG_W'(s_quot);
            l_avg_reg     <= AVG_W'(l_quot);
            s_rdy_out_reg <= s_rdy_reg;
            l_rdy_out_reg <= l_rdy_reg;
            sig_reg       <= sig;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wp_reg] <= price_reg;
        rd_data_reg <= ring_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Serial arithmetic units, all started together in ST_UPD
    // ------------------------------------------------------------------
    ma_xo_div #(.TOT_W(TOT_W), .WIN_W(WIN_W)) u_div_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .total    (s_eff),
        .window   (win_s_reg),
        .busy     (div_s_busy),
        .quotient (s_quot)
    );

    ma_xo_div #(.TOT_W(TOT_W), .WIN_W(WIN_W)) u_div_l (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .total    (l_eff),
        .window   (win_l_reg),
        .busy     (div_l_busy),
        .quotient (l_quot)
    );

    ma_xo_mul #(.TOT_W(TOT_W), .WIN_W(WIN_W)) u_mul_s (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (unit_start),
        .total   (s_eff),
        .window  (win_l_reg),
        .busy    (mul_s_busy),
        .product (lhs)
    );

    ma_xo_mul #(.TOT_W(TOT_W), .WIN_W(WIN_W)) u_mul_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (unit_start),
        .total   (l_eff),
        .window  (win_s_reg),
        .busy    (mul_l_busy),
        .product (rhs)
    );

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign short_average = s_avg_reg;
    assign long_average  = l_avg_reg;
    assign short_ready   = s_rdy_out_reg;
    assign long_ready    = l_rdy_out_reg;
    assign cross_signal  = sig_reg;

endmodule

// ===== design/ma_xo_div.sv =====
// ---------------------------------------------------------------------------
// ma_xo_div
// Bit-serial restoring divider: (total << FRAC_BITS) / window, one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module ma_xo_div
    import ma_xo_pkg::*;
#(
    parameter int TOT_W = 32,
    parameter int WIN_W = 9
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [TOT_W-1:0]              total,
    input  logic [WIN_W-1:0]              window,
    output logic                          busy,
    output logic [TOT_W+FRAC_BITS-1:0]    quotient
);

    localparam int NUM_W = TOT_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [WIN_W-1:0] rem_reg;
    logic [NUM_W-1:0] nq_reg;     // dividend bits leave at the top, quotient enters below

    logic [WIN_W:0]   rem_sh;
    logic [WIN_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, nq_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, window};
    assign rem_sub = rem_sh - {1'b0, window};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            nq_reg  <= {total, {FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
            nq_reg  <= {nq_reg[NUM_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = nq_reg;

endmodule

// ===== design/ma_xo_mul.sv =====
// ---------------------------------------------------------------------------
// ma_xo_mul
// Bit-serial shift-add multiplier: total * window, one multiplier bit of
// total per cycle, adder only as wide as the window.
// ---------------------------------------------------------------------------
module ma_xo_mul
    import ma_xo_pkg::*;
#(
    parameter int TOT_W = 32,
    parameter int WIN_W = 9
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [TOT_W-1:0]        total,
    input  logic [WIN_W-1:0]        window,
    output logic                    busy,
    output logic [TOT_W+WIN_W-1:0]  product
);

    localparam int PROD_W = TOT_W + WIN_W;
    localparam int CNT_W  = $clog2(TOT_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [WIN_W:0]    sum;

    assign sum = {1'b0, prod_reg[PROD_W-1:TOT_W]}
               + (prod_reg[0] ? {1'b0, window} : {(WIN_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(TOT_W);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= {{WIN_W{1'b0}}, total};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[TOT_W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = prod_reg;

endmodule

// ===== design/ma_xo_chk.sv =====
// ---------------------------------------------------------------------------
// ma_xo_chk
// Port-level checks on the result channel of the crossover block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ma_xo_chk
    import ma_xo_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [AVG_W-1:0] short_average,
    input logic [AVG_W-1:0] long_average,
    input logic             short_ready,
    input logic             long_ready,
    input logic [1:0]       cross_signal
);

    // A stalled result holds
    `MA_XO_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(short_average) && $stable(long_average) && $stable(cross_signal))

    // Only defined crossover codes leave the block
    `MA_XO_ASSERT_IMP(a_sig_code, out_valid, cross_signal == SIG_NONE || cross_signal == SIG_BUY || cross_signal == SIG_SELL)

    // A window that has not filled reports a zero average
    `MA_XO_ASSERT_IMP(a_short_zero, out_valid && !short_ready, short_average == '0)
    `MA_XO_ASSERT_IMP(a_long_zero, out_valid && !long_ready, long_average == '0)

endmodule

bind moving_average_crossover_top ma_xo_chk u_ma_xo_chk (.*);
